@@ src/assert_macros.svh @@
// assertion macros shared by the rtl files
// needs clk and rst_n in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold in every cycle out of reset
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/soat_pkg.sv @@
// shared types and codes for the self-organizing table
// no dependencies
package soat_pkg;

  typedef enum logic [2:0] {
    CMD_APPEND    = 3'd0,
    CMD_INSERT    = 3'd1,
    CMD_DELETE    = 3'd2,
    CMD_SEARCH    = 3'd3,
    CMD_SEARCH_TR = 3'd4,
    CMD_SEARCH_MF = 3'd5
  } soat_cmd_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_MISS   = 2'd1,
    ST_BADPOS = 2'd2,
    ST_FULL   = 2'd3
  } soat_status_t;

  typedef enum logic [2:0] {
    OP_HOLD      = 3'd0,
    OP_APPEND    = 3'd1,
    OP_INSERT    = 3'd2,
    OP_DELETE    = 3'd3,
    OP_TRANSPOSE = 3'd4,
    OP_TO_FRONT  = 3'd5
  } soat_cell_op_t;

  typedef struct packed {
    logic [2:0]         command;
    logic [8:0]         position;
    logic signed [31:0] value;
  } soat_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [7:0]         found_position;
    logic signed [31:0] removed_value;
    logic [8:0]         entry_count;
  } soat_out_t;

  // broadcast to every cell
  typedef struct packed {
    soat_cell_op_t      op;
    logic               pos_match;
    logic signed [31:0] data;
  } soat_cell_ctl_t;

endpackage

@@ src/self_organizing_array_table_top.sv @@
// self-organizing packed table: row of entry cells plus a find-first tree
// depends on soat_pkg, soat_cell, soat_find and assert_macros.svh
//
// Usage:
//   in_item carries command, position and value; an item is taken at a clock
//   edge where start is high and busy is low.
//   out_item carries status, found_position, removed_value and entry_count;
//   it is valid for exactly one cycle while out_strobe is high and cannot be
//   held off by the receiver.
//   cfg_we with cfg_wdata writes the capacity register; write only while idle.
// Timing:
//   append, insert and unused codes finish in S_DECODE; out_strobe rises as
//   busy drops, so the block takes no new item before the last one is done.
//   delete and the searches pass through S_DECODE, S_SCAN and S_APPLY: decode
//   loads the match bits, the scan state walks the registered find-first tree
//   to its root, and the apply state does the shift or swap.
//   busy drops as the result is registered, so the next item can be taken in
//   the cycle where out_strobe is high.
// Reset:
//   synchronous, active low; entry count goes to zero, capacity to 256.
//   entry contents are not cleared; only positions below the count are read.
module self_organizing_array_table_top #(
  parameter int unsigned DEPTH = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  soat_pkg::soat_in_t  in_item,
  output logic                out_strobe,
  output soat_pkg::soat_out_t out_item,
  input  logic                cfg_we,
  input  logic [8:0]          cfg_wdata
);
  import soat_pkg::*;

  localparam int unsigned CW  = $clog2(DEPTH + 1);
  localparam int unsigned IW  = $clog2(DEPTH);
  localparam int unsigned W   = (CW > 9) ? CW : 9;
  localparam int unsigned SCW = $clog2(IW + 1);
  localparam logic [W-1:0]   DEPTH_W   = W'(DEPTH);
  localparam logic [SCW-1:0] SCAN_LAST = SCW'(IW - 1);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_DECODE = 4'b0010,
    S_SCAN   = 4'b0100,
    S_APPLY  = 4'b1000
  } state_t;

  state_t             state_r, state_nxt;
  logic [2:0]         cmd_r;
  logic [8:0]         pos_r;
  logic signed [31:0] val_r;
  logic [SCW-1:0]     cnt_r, cnt_nxt;
  logic [CW-1:0]      fill_r, fill_nxt;
  logic [8:0]         cap_r;
  soat_out_t          out_r, out_nxt;
  logic               out_strobe_r, out_strobe_nxt;

  soat_cell_ctl_t     ctl;
  logic [W-1:0]       tgt;
  logic [W-1:0]       fill_w;
  logic [W-1:0]       pos_w;
  logic [W-1:0]       cap_w;
  logic [W-1:0]       eff_cap;
  logic               full;

  logic signed [31:0] ent [DEPTH];
  logic [DEPTH-1:0]   hit;
  logic               root_hit;
  logic [IW-1:0]      root_idx;
  logic signed [31:0] root_val;

  assign fill_w  = W'(fill_r);
  assign pos_w   = W'(pos_r);
  assign cap_w   = W'(cap_r);
  assign eff_cap = (cap_w > DEPTH_W) ? DEPTH_W : cap_w;
  assign full    = (fill_w >= eff_cap);

  // entry row
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [31:0] left_v, right_v;
    if (i == 0) begin : g_first
      assign left_v = ent[i];
    end else begin : g_mid_l
      assign left_v = ent[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_v = ent[i];
    end else begin : g_mid_r
      assign right_v = ent[i+1];
    end
    soat_cell #(
      .INDEX (i),
      .W     (W)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .tgt       (tgt),
      .lim       (fill_w),
      .left_val  (left_v),
      .right_val (right_v),
      .head_val  (ent[0]),
      .entry     (ent[i]),
      .match     (hit[i])
    );
  end

  soat_find #(
    .DEPTH (DEPTH)
  ) u_find (
    .clk      (clk),
    .leaf_hit (hit),
    .leaf_val (ent),
    .root_hit (root_hit),
    .root_idx (root_idx),
    .root_val (root_val)
  );

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    fill_nxt       = fill_r;
    out_nxt        = out_r;
    out_strobe_nxt = 1'b0;
    ctl.op         = OP_HOLD;
    ctl.pos_match  = (cmd_r == CMD_DELETE);
    ctl.data       = val_r;
    tgt            = pos_w;

    unique case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        out_nxt.status         = ST_OK;
        out_nxt.found_position = '0;
        out_nxt.removed_value  = '0;
        cnt_nxt                = SCAN_LAST;
        state_nxt              = S_IDLE;
        out_strobe_nxt         = 1'b1;
        unique case (cmd_r)
          CMD_APPEND: begin
            tgt = fill_w;
            if (full) begin
              out_nxt.status = ST_FULL;
            end else begin
              ctl.op   = OP_APPEND;
              fill_nxt = fill_r + 1'b1;
            end
          end
          CMD_INSERT: begin
            priority if (pos_w > fill_w) begin
              out_nxt.status = ST_BADPOS;
            end else if (full) begin
              out_nxt.status = ST_FULL;
            end else begin
              ctl.op   = OP_INSERT;
              fill_nxt = fill_r + 1'b1;
            end
          end
          CMD_DELETE, CMD_SEARCH, CMD_SEARCH_TR, CMD_SEARCH_MF: begin
            // match bits load into the tree at the end of this cycle
            state_nxt      = S_SCAN;
            out_strobe_nxt = 1'b0;
          end
          default: ;
        endcase
        out_nxt.entry_count = 9'(fill_nxt);
      end
      S_SCAN: begin
        if (cnt_r == '0) state_nxt = S_APPLY;
        else cnt_nxt = cnt_r - 1'b1;
      end
      S_APPLY: begin
        out_nxt.status         = ST_OK;
        out_nxt.found_position = '0;
        out_nxt.removed_value  = '0;
        state_nxt              = S_IDLE;
        out_strobe_nxt         = 1'b1;
        tgt                    = W'(root_idx);
        if (cmd_r == CMD_DELETE) begin
          tgt = pos_w;
          if (pos_w >= fill_w) begin
            out_nxt.status = ST_BADPOS;
          end else begin
            ctl.op                = OP_DELETE;
            out_nxt.removed_value = root_val;
            fill_nxt              = fill_r - 1'b1;
          end
        end else if (!root_hit) begin
          out_nxt.status = ST_MISS;
        end else begin
          out_nxt.found_position = 8'(root_idx);
          if (cmd_r == CMD_SEARCH_TR && root_idx != '0) ctl.op = OP_TRANSPOSE;
          else if (cmd_r == CMD_SEARCH_MF) ctl.op = OP_TO_FRONT;
        end
        out_nxt.entry_count = 9'(fill_nxt);
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      fill_r       <= '0;
      cap_r        <= 9'd256;
      cnt_r        <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      fill_r       <= fill_nxt;
      cnt_r        <= cnt_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (cfg_we) cap_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) begin
      cmd_r <= in_item.command;
      pos_r <= in_item.position;
      val_r <= in_item.value;
    end
    out_r <= out_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_item   = out_r;

`include "assert_macros.svh"

  `ASSERT_ALWAYS(a_fill_bound, fill_w <= DEPTH_W, "entry count above table depth")
  `ASSERT_IMPL(a_strobe_idle, out_strobe_r, state_r == S_IDLE, "result shown while busy")
  `ASSERT_NEXT(a_accept_decode, start && !busy, state_r == S_DECODE,
               "accepted item not decoded")
  `ASSERT_NEXT(a_scan_apply, state_r == S_SCAN && cnt_r == '0, state_r == S_APPLY,
               "tree walk did not end in apply")

endmodule

@@ src/soat_cell.sv @@
// one table entry: holds its value and moves it to or from its neighbors
// depends on soat_pkg
module soat_cell #(
  parameter int unsigned INDEX = 0,
  parameter int unsigned W     = 9
) (
  input  logic                    clk,
  input  soat_pkg::soat_cell_ctl_t ctl,
  input  logic [W-1:0]            tgt,
  input  logic [W-1:0]            lim,
  input  logic signed [31:0]      left_val,
  input  logic signed [31:0]      right_val,
  input  logic signed [31:0]      head_val,
  output logic signed [31:0]      entry,
  output logic                    match
);
  import soat_pkg::*;

  localparam logic [W-1:0] IDX      = W'(INDEX);
  localparam logic [W-1:0] IDX_NEXT = W'(INDEX + 1);
  localparam logic [W-1:0] IDX_ZERO = '0;

  logic signed [31:0] entry_r;
  logic signed [31:0] entry_nxt;

  always_comb begin
    entry_nxt = entry_r;
    unique case (ctl.op)
      OP_HOLD: entry_nxt = entry_r;
      OP_APPEND: begin
        if (IDX == tgt) entry_nxt = ctl.data;
      end
      OP_INSERT: begin
        if (IDX > tgt) entry_nxt = left_val;
        else if (IDX == tgt) entry_nxt = ctl.data;
      end
      OP_DELETE: begin
        if (IDX >= tgt) entry_nxt = right_val;
      end
      OP_TRANSPOSE: begin
        // the hit holds the key, so the cell before it takes the key
        if (IDX_NEXT == tgt) entry_nxt = ctl.data;
        else if (IDX == tgt) entry_nxt = left_val;
      end
      OP_TO_FRONT: begin
        priority if (IDX == IDX_ZERO) entry_nxt = ctl.data;
        else if (IDX == tgt) entry_nxt = head_val;
        else entry_nxt = entry_r;
      end
      default: entry_nxt = entry_r;
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;
  assign match = ctl.pos_match ? (IDX == tgt) : ((entry_r == ctl.data) && (IDX < lim));

endmodule

@@ src/soat_find.sv @@
// registered find-first tree over the cell match bits, one level per cycle
// carries the index and value of the lowest matching cell; no package use
module soat_find #(
  parameter int unsigned DEPTH = 256
) (
  input  logic                       clk,
  input  logic [DEPTH-1:0]           leaf_hit,
  input  logic signed [31:0]         leaf_val [DEPTH],
  output logic                       root_hit,
  output logic [$clog2(DEPTH)-1:0]   root_idx,
  output logic signed [31:0]         root_val
);
  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned P  = 1 << IW;

  // heap layout: node n has children 2n and 2n+1, leaves at P .. 2P-1
  logic               hit_r [1:2*P-1];
  logic [IW-1:0]      idx_r [1:2*P-1];
  logic signed [31:0] val_r [1:2*P-1];

  for (genvar i = 0; i < P; i++) begin : g_leaf
    if (i < DEPTH) begin : g_real
      always_ff @(posedge clk) begin
        hit_r[P+i] <= leaf_hit[i];
        idx_r[P+i] <= IW'(i);
        val_r[P+i] <= leaf_val[i];
      end
    end else begin : g_pad
      always_ff @(posedge clk) begin
        hit_r[P+i] <= 1'b0;
        idx_r[P+i] <= IW'(i);
        val_r[P+i] <= '0;
      end
    end
  end

  for (genvar n = 1; n < P; n++) begin : g_node
    always_ff @(posedge clk) begin
      hit_r[n] <= hit_r[2*n] | hit_r[2*n+1];
      idx_r[n] <= hit_r[2*n] ? idx_r[2*n] : idx_r[2*n+1];
      val_r[n] <= hit_r[2*n] ? val_r[2*n] : val_r[2*n+1];
    end
  end

  assign root_hit = hit_r[1];
  assign root_idx = idx_r[1];
  assign root_val = val_r[1];

endmodule

@@ test/tb_self_organizing_array_table_top.sv @@
// testbench for self_organizing_array_table_top: directed and random commands, results
// checked against a behavioral table model kept in a small scoreboard class
// depends on soat_pkg and the rtl under src
module tb_self_organizing_array_table_top;
  import soat_pkg::*;

  localparam int unsigned TABLE_DEPTH = 256;
  localparam int unsigned DRAIN_CYCLES = 14;
  localparam logic [2:0] CMD_UNUSED_LO = 3'd6;
  localparam logic [2:0] CMD_UNUSED_HI = 3'd7;
  localparam int NUM_PHASES = 8;

  class table_scoreboard;
    logic signed [31:0] slots [TABLE_DEPTH];
    int unsigned fill;
    int unsigned capacity;
    soat_out_t expected_replies [$];
    int errors;

    function new();
      fill = 0;
      capacity = 256;
      errors = 0;
      foreach (slots[i]) slots[i] = '0;
    endfunction

    function void set_capacity(logic [8:0] v);
      capacity = 32'(v);
    endfunction

    function int unsigned pending();
      return expected_replies.size();
    endfunction

    // updates the table for one accepted item and queues the reply it must give
    function void apply_command(soat_in_t it);
      soat_out_t r;
      int unsigned lim;
      int unsigned hit;
      int unsigned i;
      int unsigned pos_i;
      bit hit_valid;
      logic signed [31:0] tmp;
      r = '0;
      hit = 0;
      hit_valid = 0;
      pos_i = 32'(it.position);
      lim = (capacity > TABLE_DEPTH) ? TABLE_DEPTH : capacity;
      case (it.command)
        CMD_APPEND: begin
          if (fill >= lim) begin
            r.status = ST_FULL;
          end else begin
            slots[fill] = it.value;
            fill++;
          end
        end
        CMD_INSERT: begin
          if (pos_i > fill) begin
            r.status = ST_BADPOS;
          end else if (fill >= lim) begin
            r.status = ST_FULL;
          end else begin
            for (i = fill; i > pos_i; i--) slots[i] = slots[i-1];
            slots[pos_i] = it.value;
            fill++;
          end
        end
        CMD_DELETE: begin
          if (pos_i >= fill) begin
            r.status = ST_BADPOS;
          end else begin
            r.removed_value = slots[pos_i];
            for (i = pos_i; i + 1 < fill; i++) slots[i] = slots[i+1];
            fill--;
          end
        end
        CMD_SEARCH, CMD_SEARCH_TR, CMD_SEARCH_MF: begin
          for (i = 0; i < fill && !hit_valid; i++) begin
            if (slots[i] == it.value) begin
              hit = i;
              hit_valid = 1;
            end
          end
          if (!hit_valid) begin
            r.status = ST_MISS;
          end else begin
            r.found_position = hit[7:0];
            if (it.command == CMD_SEARCH_TR && hit > 0) begin
              tmp = slots[hit-1];
              slots[hit-1] = slots[hit];
              slots[hit] = tmp;
            end else if (it.command == CMD_SEARCH_MF) begin
              tmp = slots[0];
              slots[0] = slots[hit];
              slots[hit] = tmp;
            end
          end
        end
        default: ;
      endcase
      r.entry_count = fill[8:0];
      expected_replies.push_back(r);
    endfunction

    function void check_result(soat_out_t got);
      soat_out_t want;
      if (expected_replies.size() == 0) begin
        $error("result with no item pending: %h", got);
        errors++;
        return;
      end
      want = expected_replies.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        errors++;
      end
      if (got.found_position !== want.found_position) begin
        $error("found_position: expected %0d, actual %0d",
               want.found_position, got.found_position);
        errors++;
      end
      if (got.removed_value !== want.removed_value) begin
        $error("removed_value: expected %0d, actual %0d",
               want.removed_value, got.removed_value);
        errors++;
      end
      if (got.entry_count !== want.entry_count) begin
        $error("entry_count: expected %0d, actual %0d", want.entry_count, got.entry_count);
        errors++;
      end
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  soat_in_t  in_item;
  logic      out_strobe;
  soat_out_t out_item;
  logic      cfg_we;
  logic [8:0] cfg_wdata;

  table_scoreboard sb;

  self_organizing_array_table_top #(
    .DEPTH(TABLE_DEPTH)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // outputs only move on the rising edge, so the falling edge sees them settled
  always @(negedge clk) begin
    if (rst_n && out_strobe) sb.check_result(out_item);
  end

  // holds the item until the block takes it; returns at the accepting edge
  task automatic send_item(input logic [2:0] cmd, input logic [8:0] pos,
                           input logic signed [31:0] val);
    soat_in_t it;
    it.command = cmd;
    it.position = pos;
    it.value = val;
    start <= 1'b1;
    in_item <= it;
    do @(negedge clk); while (busy !== 1'b0);
    @(posedge clk);
    sb.apply_command(it);
  endtask

  task automatic idle_cycles(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [8:0] v);
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_capacity(v);
  endtask

  // small pool of corner values so that duplicates and sign extremes show up
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4: return 32'sd0;
      5: return -32'sd1;
      6: return 32'sh8000_0000;
      7: return 32'sh7fff_ffff;
      default: return $urandom_range(0, 7);
    endcase
  endfunction

  function automatic logic signed [31:0] pick_key();
    if (sb.fill > 0 && $urandom_range(0, 99) < 70)
      return sb.slots[$urandom_range(0, sb.fill - 1)];
    return pick_value();
  endfunction

  task automatic send_random(input int add_pct, input int del_pct);
    int r;
    logic [2:0] cmd;
    logic [8:0] pos;
    logic signed [31:0] val;
    r = $urandom_range(0, 99);
    pos = 9'($urandom_range(0, 511));
    val = pick_value();
    if (r < add_pct) begin
      if ($urandom_range(0, 1) == 0) begin
        cmd = CMD_APPEND;
      end else begin
        cmd = CMD_INSERT;
        if ($urandom_range(0, 99) < 85) pos = 9'($urandom_range(0, sb.fill));
      end
    end else if (r < add_pct + del_pct) begin
      cmd = CMD_DELETE;
      if (sb.fill > 0 && $urandom_range(0, 99) < 85)
        pos = 9'($urandom_range(0, sb.fill - 1));
    end else begin
      case ($urandom_range(0, 12))
        0, 1, 2, 3: cmd = CMD_SEARCH;
        4, 5, 6, 7: cmd = CMD_SEARCH_TR;
        8, 9, 10, 11: cmd = CMD_SEARCH_MF;
        default: cmd = $urandom_range(0, 1) ? CMD_UNUSED_HI : CMD_UNUSED_LO;
      endcase
      val = pick_key();
    end
    send_item(cmd, pos, val);
  endtask

  initial begin
    int unsigned caps [NUM_PHASES] = '{511, 256, 0, 1, 12, 256, 0, 256};
    int          lens [NUM_PHASES] = '{320, 160, 60, 260, 260, 200, 160, 180};
    int          adds [NUM_PHASES] = '{85, 30, 50, 10, 45, 35, 45, 40};
    int          dels [NUM_PHASES] = '{5, 30, 10, 75, 25, 30, 25, 30};
    int unsigned cap;
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    sb = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table: miss and bad positions, then appends, inserts and a search
    send_item(CMD_SEARCH, 9'd0, 32'sd0);
    send_item(CMD_DELETE, 9'd0, 32'sd0);
    send_item(CMD_INSERT, 9'd1, 32'sd3);
    send_item(CMD_INSERT, 9'd0, 32'sh7fff_ffff);
    send_item(CMD_APPEND, 9'h1ff, 32'sh8000_0000);
    send_item(CMD_APPEND, 9'd0, -32'sd1);
    send_item(CMD_APPEND, 9'd0, 32'sd0);
    send_item(CMD_INSERT, 9'd4, 32'sd5);
    send_item(CMD_INSERT, 9'd2, 32'sd9);
    send_item(CMD_APPEND, 9'd0, 32'sd5);
    send_item(CMD_SEARCH, 9'h1ff, 32'sd5);
    // transpose hit at the head swaps nothing
    send_item(CMD_SEARCH_TR, 9'd0, 32'sh7fff_ffff);
    send_item(CMD_SEARCH_TR, 9'd0, -32'sd1);
    send_item(CMD_SEARCH_MF, 9'd0, 32'sd5);
    send_item(CMD_SEARCH_MF, 9'd0, sb.slots[0]);
    send_item(CMD_SEARCH_MF, 9'd0, 32'sd12345);
    send_item(CMD_UNUSED_LO, 9'h1ff, 32'shffff_ffff);
    send_item(CMD_UNUSED_HI, 9'd0, 32'sd0);
    send_item(CMD_DELETE, 9'h1ff, 32'sd0);
    send_item(CMD_DELETE, 9'd256, 32'sd0);
    send_item(CMD_DELETE, 9'(sb.fill - 1), 32'sd0);
    send_item(CMD_DELETE, 9'd0, 32'sd0);
    send_item(CMD_INSERT, 9'd256, 32'sd1);
    send_item(CMD_INSERT, 9'(sb.fill), 32'sh8000_0000);

    for (int p = 0; p < NUM_PHASES; p++) begin
      cap = (p == 6) ? $urandom_range(1, 40) : caps[p];
      write_capacity(cap[8:0]);
      for (int k = 0; k < lens[p]; k++) begin
        send_random(adds[p], dels[p]);
        // quiet stretches in two of every three windows, none in the closing phase
        if (p != NUM_PHASES - 1 && (k / 40) % 3 != 2 && $urandom_range(0, 3) == 0)
          idle_cycles($urandom_range(1, 4));
      end
    end

    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("[self_organizing_array_table_top] OK");
    end else begin
      $display("[self_organizing_array_table_top] ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("[self_organizing_array_table_top] ERROR");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+src
src/soat_pkg.sv
src/soat_cell.sv
src/soat_find.sv
src/self_organizing_array_table_top.sv
test/tb_self_organizing_array_table_top.sv
